FILE: rtl/dsi_pkg.sv
package dsi_pkg;

  localparam int unsigned JOYSTICK_BITS_DEF = 10;

  localparam int unsigned SPEED_W   = 12;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned DB_W      = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W    = 3;

  // mode, left_speed, right_speed, motors_on
  localparam int unsigned OUT_FIELDS_W = MODE_W + 2 * SPEED_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SPEED_W-1:0] NEUTRAL_SPEED = SPEED_W'(1500);
  localparam logic [TICK_W-1:0]  TICK_MAX      = '1;

  localparam logic [DB_W-1:0]    DEADBAND_RST    = DB_W'(20);
  localparam logic [SPEED_W-1:0] UPPER_LIMIT_RST = SPEED_W'(2000);
  localparam logic [SPEED_W-1:0] LOWER_LIMIT_RST = SPEED_W'(1000);
  localparam logic [TICK_W-1:0]  POWER_ON_RST    = TICK_W'(5000);
  localparam logic [TICK_W-1:0]  INIT_RST        = TICK_W'(2000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEADBAND    = 3'd0,
    REG_UPPER_LIMIT = 3'd1,
    REG_LOWER_LIMIT = 3'd2,
    REG_POWER_ON    = 3'd3,
    REG_INIT        = 3'd4
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_POWER_ON    = 3'd0,
    MODE_INIT        = 3'd1,
    MODE_DISABLED    = 3'd2,
    MODE_ENABLED     = 3'd3,
    MODE_CTRL_FAULT  = 3'd4,
    MODE_BATT_FAULT  = 3'd5
  } mode_e;

  typedef struct packed {
    logic [DB_W-1:0]    deadband;
    logic [SPEED_W-1:0] upper_limit;
    logic [SPEED_W-1:0] lower_limit;
    logic [TICK_W-1:0]  power_on_ticks;
    logic [TICK_W-1:0]  init_ticks;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] next_mode;
    logic              drive;
  } lock_t;

endpackage

FILE: rtl/dsi_cfg_regs.sv
module dsi_cfg_regs
  import dsi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_DEADBAND:    cfg_d.deadband       = cfg_data_i[DB_W-1:0];
        REG_UPPER_LIMIT: cfg_d.upper_limit    = cfg_data_i[SPEED_W-1:0];
        REG_LOWER_LIMIT: cfg_d.lower_limit    = cfg_data_i[SPEED_W-1:0];
        REG_POWER_ON:    cfg_d.power_on_ticks = cfg_data_i[TICK_W-1:0];
        REG_INIT:        cfg_d.init_ticks     = cfg_data_i[TICK_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband       <= DEADBAND_RST;
      cfg_q.upper_limit    <= UPPER_LIMIT_RST;
      cfg_q.lower_limit    <= LOWER_LIMIT_RST;
      cfg_q.power_on_ticks <= POWER_ON_RST;
      cfg_q.init_ticks     <= INIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/dsi_interlock.sv
module dsi_interlock
  import dsi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  enable_i,
  input  logic  charge_i,
  input  logic  centered_i,
  input  cfg_t  cfg_i,
  output lock_t lock_o
);

  mode_e             mode_q, mode_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_POWER_ON: begin
        if (ticks_q > cfg_i.power_on_ticks) mode_d = MODE_INIT;
      end
      MODE_INIT: begin
        if (charge_i) mode_d = MODE_BATT_FAULT;
        else if (enable_i || !centered_i) mode_d = MODE_CTRL_FAULT;
        else if (ticks_q > cfg_i.init_ticks) mode_d = MODE_DISABLED;
      end
      MODE_DISABLED: begin
        if (charge_i) mode_d = MODE_BATT_FAULT;
        else if (!centered_i) mode_d = MODE_CTRL_FAULT;
        else if (enable_i) mode_d = MODE_ENABLED;
      end
      MODE_ENABLED: begin
        if (charge_i) mode_d = MODE_BATT_FAULT;
        else if (!enable_i) mode_d = MODE_DISABLED;
      end
      MODE_CTRL_FAULT: begin
        if (charge_i) mode_d = MODE_BATT_FAULT;
        else if (!enable_i && centered_i) mode_d = MODE_INIT;
      end
      MODE_BATT_FAULT: mode_d = MODE_BATT_FAULT;
      default:         mode_d = MODE_POWER_ON;
    endcase

    if (mode_d != mode_q) begin
      ticks_d = '0;
    end else if (ticks_q != TICK_MAX) begin
      ticks_d = ticks_q + TICK_W'(1);
    end else begin
      ticks_d = ticks_q;
    end

    lock_o.next_mode = mode_d;
    lock_o.drive     = (mode_q == MODE_ENABLED) && (mode_d == MODE_ENABLED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_POWER_ON;
      ticks_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

FILE: rtl/dsi_mixer.sv
module dsi_mixer
  import dsi_pkg::*;
#(
  parameter int unsigned JOYSTICK_BITS = JOYSTICK_BITS_DEF
) (
  input  logic [JOYSTICK_BITS-1:0] joy_x_i,
  input  logic [JOYSTICK_BITS-1:0] joy_y_i,
  input  cfg_t                     cfg_i,
  output logic [SPEED_W-1:0]       left_o,
  output logic [SPEED_W-1:0]       right_o
);

  localparam int unsigned DW  = JOYSTICK_BITS + 3;
  localparam int unsigned SW  = DW + 2;
  localparam int unsigned QS  = DW + 1;
  localparam int unsigned PW  = QS + (DW - 1);
  localparam logic [QS-2:0] RECIP3 = (QS-1)'(((1 << QS) + 2) / 3);
  localparam logic signed [DW-1:0] CENTER = DW'(1 << (JOYSTICK_BITS - 1));

  logic signed [DW-1:0] fwd, turn, turn_q3;
  logic        [DW-2:0] turn_mag, q_mag;
  logic        [PW-1:0] prod;
  logic signed [SW-1:0] sum_l, sum_r;

  function automatic logic signed [DW-1:0] dead(input logic [JOYSTICK_BITS-1:0] raw,
                                                input logic [DB_W-1:0] db);
    logic signed [DW-1:0] v, hi, lo, r;
    v  = $signed(DW'(raw));
    hi = CENTER + $signed(DW'(db));
    lo = CENTER - $signed(DW'(db));
    if (v > hi) r = v - hi;
    else if (v < lo) r = v - lo;
    else r = '0;
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] clamp(input logic signed [SW-1:0] s,
                                               input cfg_t c);
    logic signed [SW-1:0] r;
    r = s;
    if (r > $signed(SW'(c.upper_limit))) r = $signed(SW'(c.upper_limit));
    if (r < $signed(SW'(c.lower_limit))) r = $signed(SW'(c.lower_limit));
    return r[SPEED_W-1:0];
  endfunction

  always_comb begin
    fwd  = dead(joy_y_i, cfg_i.deadband);
    turn = dead(joy_x_i, cfg_i.deadband);
    // truncating divide by three on the magnitude
    turn_mag = turn[DW-1] ? (DW-1)'(-turn) : turn[DW-2:0];
    prod     = PW'(turn_mag) * PW'(RECIP3);
    q_mag    = prod[QS +: (DW-1)];
    turn_q3  = turn[DW-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sum_l = $signed(SW'(NEUTRAL_SPEED)) + SW'(fwd) + SW'(turn_q3);
    sum_r = $signed(SW'(NEUTRAL_SPEED)) + SW'(fwd) - SW'(turn_q3);
    left_o  = clamp(sum_l, cfg_i);
    right_o = clamp(sum_r, cfg_i);
  end

endmodule

FILE: rtl/drive_safety_interlock_mixer_core.sv
// Datapath: an accepted item is held in the input register, and its result
// is then held in the result register until it is taken.
// Throughput: one item per cycle, limited only by the result register
// draining on m_axis_tready.
// Reset: asynchronous active low; mode power-on, tick count zero,
// registers at their defaults, both item registers empty.
module drive_safety_interlock_mixer_core
  import dsi_pkg::*;
#(
  parameter int unsigned JOYSTICK_BITS = JOYSTICK_BITS_DEF,
  localparam int unsigned IN_FIELDS_W = 2 * JOYSTICK_BITS + 3,
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // joy_x, joy_y, enable_pressed, charge_needed, stick_centered
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mode, left_speed, right_speed, motors_on
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned JB = JOYSTICK_BITS;

  logic                   in_valid_q;
  logic [IN_FIELDS_W-1:0] in_data_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   advance;

  cfg_t               cfg;
  lock_t              lock;
  logic [SPEED_W-1:0] mix_left, mix_right;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  dsi_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  dsi_interlock u_lock (
    .clk_i,
    .rst_ni,
    .advance_i  (advance),
    .enable_i   (in_data_q[2*JB]),
    .charge_i   (in_data_q[2*JB+1]),
    .centered_i (in_data_q[2*JB+2]),
    .cfg_i      (cfg),
    .lock_o     (lock)
  );

  dsi_mixer #(
    .JOYSTICK_BITS (JOYSTICK_BITS)
  ) u_mix (
    .joy_x_i (in_data_q[JB-1:0]),
    .joy_y_i (in_data_q[2*JB-1:JB]),
    .cfg_i   (cfg),
    .left_o  (mix_left),
    .right_o (mix_right)
  );

  always_comb begin
    out_data_d = '0;
    out_data_d[MODE_W-1:0] = lock.next_mode;
    out_data_d[MODE_W +: SPEED_W] = lock.drive ? mix_left : NEUTRAL_SPEED;
    out_data_d[MODE_W+SPEED_W +: SPEED_W] = lock.drive ? mix_right : NEUTRAL_SPEED;
    out_data_d[MODE_W+2*SPEED_W] = lock.drive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_data_q <= s_axis_tdata[IN_FIELDS_W-1:0];
    if (advance) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
